// ===== rtl/lsm_pkg.sv =====
// Shared types, opcodes, class codes and reset constants of the latency stats monitor.
package lsm_pkg;

  // Default ring size per timed class (power of two)
  localparam int unsigned RING_SAMPLES_DEF = 64;

  // Minimum preload after reset
  localparam logic [31:0] MIN_PRELOAD_RESET = 32'd10000;

  // Saturation value for elapsed time
  localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

  // Event opcodes
  localparam logic [3:0] OP_START           = 4'd0;
  localparam logic [3:0] OP_READ_DONE       = 4'd1;
  localparam logic [3:0] OP_SYNC_DONE       = 4'd3;
  localparam logic [3:0] OP_WARN_WRAP       = 4'd4;
  localparam logic [3:0] OP_WARN_FIFO_FULL  = 4'd7;
  localparam logic [3:0] OP_REPORT          = 4'd8;

  // Result classes
  localparam logic [2:0] CLS_READ      = 3'd0;
  localparam logic [2:0] CLS_SYNC      = 3'd2;
  localparam logic [2:0] CLS_WARN_WRAP = 3'd3;
  localparam logic [2:0] CLS_START     = 3'd7;

  // Kind of work an item carries into the update stage
  typedef enum logic [1:0] {
    KIND_START,
    KIND_TIMED,
    KIND_WARN,
    KIND_REPORT
  } item_kind_t;

  // Input item
  typedef struct packed {
    logic [3:0]  opcode;
    logic [63:0] time_us;
    logic [2:0]  report_class;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [2:0]  stat_class;
    logic [31:0] last_delta_us;
    logic [31:0] min_us;
    logic [31:0] max_us;
    logic [31:0] event_count;
    logic [31:0] average_us;
  } out_item_t;

  // Decoded item handed from the front stage to the stats update
  typedef struct packed {
    item_kind_t  kind;
    logic [2:0]  cls;       // result class code
    logic [31:0] delta;     // saturated elapsed time
    logic        old_live;  // ring slot already written once
  } stage_item_t;

endpackage

// ===== rtl/latency_stats_monitor.sv =====
// Top level of the latency stats monitor: front decode stage, ring memory, stats, output register.
//
// Usage:
//   Input channel (in_valid / in_stall / in_item) carries timestamped events:
//   start, read/write/sync completion, four warning kinds and report.
//   Opcodes above report are dropped without a result; every other item
//   yields exactly one result on the output channel (out_valid / out_stall /
//   out_item), in order.
//   Configuration: cfg_we with cfg_wdata loads the minimum preload into all
//   three timed-class minima. Write only while no item is in flight.
// Pipeline:
//   An accepted item passes the update stage, then the output register. One
//   item per cycle is sustained while out_stall is low: the ring read is
//   issued at accept, the old sample waits in the memory's read register,
//   and the update stage read-modify-writes the class stats and ring slot.
// Reset (rst_n low, synchronous): all statistics, positions and the start
//   stamp clear, minima load 10000. Ring slots not yet written since reset
//   read as zero through a per-class wrap flag; no clearing pass is needed.
// Stall: when out_stall holds a result, one more item is held in the update
//   stage, and after that in_stall rises until the output drains.
module latency_stats_monitor #(
  parameter int unsigned RING_SAMPLES = lsm_pkg::RING_SAMPLES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  lsm_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output lsm_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic [31:0]        cfg_wdata
);

  localparam int unsigned POS_W      = $clog2(RING_SAMPLES);
  localparam int unsigned ADDR_W     = POS_W + 2;
  localparam int unsigned RING_DEPTH = 3 * RING_SAMPLES;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(RING_SAMPLES - 1);

  logic [63:0]         start_stamp_r;
  logic [POS_W-1:0]    pos_r [0:2];
  logic [2:0]          wrapped_r;
  logic                s1_valid_r;
  lsm_pkg::stage_item_t s1_item_r;
  logic [POS_W-1:0]    s1_pos_r;
  logic                out_valid_r;
  lsm_pkg::out_item_t  out_item_r;

  logic                accept;
  logic                s1_fire;
  logic                is_start;
  logic                is_timed;
  logic                is_warn;
  logic                is_report;
  logic                op_ok;
  logic [1:0]          tc_idx;
  logic [POS_W-1:0]    pos_cur;
  logic [POS_W-1:0]    pos_nxt;
  logic [63:0]         d64;
  logic [31:0]         delta;
  lsm_pkg::stage_item_t s1_item_nxt;
  logic [31:0]         rd_data;
  lsm_pkg::out_item_t  result;

  // Handshake: update stage moves when the output register is free or draining
  assign s1_fire  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_fire;
  assign accept   = in_valid && !in_stall;

  // Opcode decode
  assign is_start  = (in_item.opcode == lsm_pkg::OP_START);
  assign is_timed  = (in_item.opcode >= lsm_pkg::OP_READ_DONE) &&
                     (in_item.opcode <= lsm_pkg::OP_SYNC_DONE);
  assign is_warn   = (in_item.opcode >= lsm_pkg::OP_WARN_WRAP) &&
                     (in_item.opcode <= lsm_pkg::OP_WARN_FIFO_FULL);
  assign is_report = (in_item.opcode == lsm_pkg::OP_REPORT);
  assign op_ok     = is_start || is_timed || is_warn || is_report;

  // Ring position of the completing class
  assign tc_idx  = is_timed ? 2'(in_item.opcode[1:0] - 2'd1) : 2'd0;
  assign pos_cur = pos_r[tc_idx];
  assign pos_nxt = (pos_cur == POS_LAST) ? '0 : pos_cur + POS_W'(1);

  // Elapsed time, saturated to 32 bits
  assign d64   = in_item.time_us - start_stamp_r;
  assign delta = (|d64[63:32]) ? lsm_pkg::SAT32 : d64[31:0];

  // Decoded item for the update stage
  always_comb begin
    s1_item_nxt          = '0;
    s1_item_nxt.kind     = lsm_pkg::KIND_START;
    s1_item_nxt.cls      = lsm_pkg::CLS_START;
    priority if (is_timed) begin
      s1_item_nxt.kind     = lsm_pkg::KIND_TIMED;
      s1_item_nxt.cls      = {1'b0, tc_idx};
      s1_item_nxt.delta    = delta;
      s1_item_nxt.old_live = wrapped_r[tc_idx];
    end else if (is_warn) begin
      s1_item_nxt.kind = lsm_pkg::KIND_WARN;
      s1_item_nxt.cls  = 3'(in_item.opcode[1:0]) + lsm_pkg::CLS_WARN_WRAP;
    end else if (is_report) begin
      s1_item_nxt.kind = lsm_pkg::KIND_REPORT;
      s1_item_nxt.cls  = in_item.report_class;
    end else begin
      s1_item_nxt.kind = lsm_pkg::KIND_START;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_stamp_r <= '0;
      for (int i = 0; i < 3; i++) begin
        pos_r[i] <= '0;
      end
      wrapped_r   <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept && is_start) begin
        start_stamp_r <= in_item.time_us;
      end
      if (accept && is_timed) begin
        pos_r[tc_idx] <= pos_nxt;
        if (pos_cur == POS_LAST) begin
          wrapped_r[tc_idx] <= 1'b1;
        end
      end
      if (accept) begin
        s1_valid_r <= op_ok;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r <= s1_item_nxt;
      s1_pos_r  <= pos_cur;
    end
    if (s1_fire) begin
      out_item_r <= result;
    end
  end

  // Ring memory: old sample read at accept, new sample written at update
  lsm_ring_mem #(
    .DEPTH  (RING_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ring (
    .clk     (clk),
    .rd_en   (accept && is_timed),
    .rd_addr ({tc_idx, pos_cur}),
    .rd_data (rd_data),
    .wr_en   (s1_fire && s1_item_r.kind == lsm_pkg::KIND_TIMED),
    .wr_addr ({s1_item_r.cls[1:0], s1_pos_r}),
    .wr_data (s1_item_r.delta)
  );

  // Class statistics
  lsm_stats #(
    .RING_SAMPLES (RING_SAMPLES),
    .POS_W        (POS_W)
  ) u_stats (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .fire       (s1_fire),
    .item       (s1_item_r),
    .old_sample (rd_data),
    .result     (result)
  );

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== rtl/lsm_ring_mem.sv =====
// Sample ring memory: one write port, one registered read port.
module lsm_ring_mem #(
  parameter int unsigned DEPTH  = 3 * lsm_pkg::RING_SAMPLES_DEF,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [31:0]       rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [31:0]       wr_data
);

  logic [31:0] mem [0:DEPTH-1];
  logic [31:0] rd_data_r;

  // Write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/lsm_stats.sv =====
// Per-class min/max/count/ring-sum and warning counters, with result formatting.
module lsm_stats #(
  parameter int unsigned RING_SAMPLES = lsm_pkg::RING_SAMPLES_DEF,
  parameter int unsigned POS_W        = $clog2(RING_SAMPLES),
  parameter int unsigned SUM_W        = 32 + POS_W
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [31:0]         cfg_wdata,
  input  logic                fire,
  input  lsm_pkg::stage_item_t item,
  input  logic [31:0]         old_sample,
  output lsm_pkg::out_item_t  result
);

  logic [31:0]      min_r  [0:2];
  logic [31:0]      max_r  [0:2];
  logic [31:0]      cnt_r  [0:2];
  logic [SUM_W-1:0] sum_r  [0:2];
  logic [31:0]      warn_r [0:3];

  logic [1:0]       tidx;
  logic [1:0]       widx;
  logic [31:0]      old_val;
  logic [31:0]      min_nxt;
  logic [31:0]      max_nxt;
  logic [31:0]      cnt_nxt;
  logic [SUM_W-1:0] sum_nxt;
  logic [31:0]      warn_nxt;
  logic             is_timed_cls;

  // Class selection; warning index is class minus three
  assign is_timed_cls = (item.cls <= lsm_pkg::CLS_SYNC);
  assign tidx         = is_timed_cls ? item.cls[1:0] : 2'd0;
  assign widx         = 2'(item.cls - lsm_pkg::CLS_WARN_WRAP);

  // Completion update values
  assign old_val  = item.old_live ? old_sample : 32'd0;
  assign min_nxt  = (item.delta < min_r[tidx]) ? item.delta : min_r[tidx];
  assign max_nxt  = (item.delta > max_r[tidx]) ? item.delta : max_r[tidx];
  assign cnt_nxt  = cnt_r[tidx] + 32'd1;
  assign sum_nxt  = sum_r[tidx] - SUM_W'(old_val) + SUM_W'(item.delta);
  assign warn_nxt = warn_r[widx] + 32'd1;

  // Result formatting
  always_comb begin
    result = '0;
    result.stat_class = lsm_pkg::CLS_START;
    unique case (item.kind)
      lsm_pkg::KIND_START: begin
        result.stat_class = lsm_pkg::CLS_START;
      end
      lsm_pkg::KIND_TIMED: begin
        result.stat_class    = item.cls;
        result.last_delta_us = item.delta;
        result.min_us        = min_nxt;
        result.max_us        = max_nxt;
        result.event_count   = cnt_nxt;
        result.average_us    = sum_nxt[SUM_W-1:POS_W];
      end
      lsm_pkg::KIND_WARN: begin
        result.stat_class  = item.cls;
        result.event_count = warn_nxt;
      end
      lsm_pkg::KIND_REPORT: begin
        priority if (is_timed_cls) begin
          result.stat_class  = item.cls;
          result.min_us      = min_r[tidx];
          result.max_us      = max_r[tidx];
          result.event_count = cnt_r[tidx];
          result.average_us  = sum_r[tidx][SUM_W-1:POS_W];
        end else if (item.cls != lsm_pkg::CLS_START) begin
          result.stat_class  = item.cls;
          result.event_count = warn_r[widx];
        end else begin
          result.stat_class = lsm_pkg::CLS_START;
        end
      end
      default: begin
        result.stat_class = lsm_pkg::CLS_START;
      end
    endcase
  end

  // State update; a preload write reloads all three minima
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        min_r[i] <= lsm_pkg::MIN_PRELOAD_RESET;
        max_r[i] <= '0;
        cnt_r[i] <= '0;
        sum_r[i] <= '0;
      end
      for (int i = 0; i < 4; i++) begin
        warn_r[i] <= '0;
      end
    end else begin
      if (fire && item.kind == lsm_pkg::KIND_TIMED) begin
        min_r[tidx] <= min_nxt;
        max_r[tidx] <= max_nxt;
        cnt_r[tidx] <= cnt_nxt;
        sum_r[tidx] <= sum_nxt;
      end
      if (fire && item.kind == lsm_pkg::KIND_WARN) begin
        warn_r[widx] <= warn_nxt;
      end
      if (cfg_we) begin
        for (int i = 0; i < 3; i++) begin
          min_r[i] <= cfg_wdata;
        end
      end
    end
  end

endmodule

// ===== rtl/lsm_checker.sv =====
// Port-level checks of the latency stats monitor, bound to the top level.
module lsm_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input lsm_pkg::out_item_t out_item
);

  // A stalled result stays and holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result dropped or changed");

  // Reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

  // Start results and class-seven reports carry only zeros
  a_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.stat_class == lsm_pkg::CLS_START |->
      out_item.last_delta_us == 32'd0 && out_item.min_us == 32'd0 &&
      out_item.max_us == 32'd0 && out_item.event_count == 32'd0 &&
      out_item.average_us == 32'd0)
    else $error("start result not zero");

  // Warning classes carry only a count
  a_warn_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.stat_class >= lsm_pkg::CLS_WARN_WRAP &&
      out_item.stat_class != lsm_pkg::CLS_START |->
      out_item.last_delta_us == 32'd0 && out_item.min_us == 32'd0 &&
      out_item.max_us == 32'd0 && out_item.average_us == 32'd0)
    else $error("warning result has timing fields");

  // A completion with a nonzero elapsed time lies between the updated minimum and maximum
  a_delta_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.stat_class <= lsm_pkg::CLS_SYNC &&
      out_item.last_delta_us != 32'd0 |->
      out_item.min_us <= out_item.last_delta_us &&
      out_item.last_delta_us <= out_item.max_us)
    else $error("completion outside min/max");

endmodule

bind latency_stats_monitor lsm_checker u_lsm_checker (.*);

// ===== tb/latency_stats_monitor_tb.sv =====
// Self-checking testbench for the latency stats monitor: directed table plus random event streams.
module latency_stats_monitor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RING = lsm_pkg::RING_SAMPLES_DEF;

  // Codes the package does not name
  localparam logic [3:0] OP_WRITE_DONE       = 4'd2;
  localparam logic [3:0] OP_WARN_ALL_FULL    = 4'd5;
  localparam logic [3:0] OP_WARN_QUEUE_FULL  = 4'd6;
  localparam logic [3:0] OP_UNUSED_LOW       = 4'd9;
  localparam logic [3:0] OP_UNUSED_HIGH      = 4'd15;
  localparam logic [2:0] CLS_WRITE           = 3'd1;
  localparam logic [2:0] CLS_WARN_ALL_FULL   = 3'd4;
  localparam logic [2:0] CLS_WARN_QUEUE_FULL = 3'd5;
  localparam logic [2:0] CLS_WARN_FIFO_FULL  = 3'd6;

  localparam int RESET_CYCLES = 9;
  localparam int DRAIN_CYCLES = 6;
  localparam int HOLD_CYCLES  = 400;

  // All-zero results of the start class and of a fresh wrap counter
  localparam lsm_pkg::out_item_t START_RES =
    '{lsm_pkg::CLS_START, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0};
  localparam lsm_pkg::out_item_t WRAP_ZERO_RES =
    '{lsm_pkg::CLS_WARN_WRAP, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0};

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  lsm_pkg::in_item_t  in_item;
  logic               out_valid;
  logic               out_stall;
  lsm_pkg::out_item_t out_item;
  logic               cfg_we;
  logic [31:0]        cfg_wdata;

  latency_stats_monitor #(
    .RING_SAMPLES(RING)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Directed table entry: stimulus, and an expected result when typed in
  typedef struct packed {
    lsm_pkg::in_item_t  stim;
    logic               typed;
    lsm_pkg::out_item_t want;
  } vector_t;

  // Mirror of the block's statistics
  logic [63:0] start_time;
  logic [31:0] lat_min [3];
  logic [31:0] lat_max [3];
  logic [31:0] lat_count [3];
  int unsigned ring_ptr [3];
  logic [31:0] sample_mem [3][RING];
  logic [37:0] ring_total [3];
  logic [31:0] warn_count [4];

  lsm_pkg::out_item_t pending_stats[$];
  int        sent_events;
  bit        failed;
  int        send_idle_pct;
  int        recv_idle_pct;
  bit        stress_on;

  // Current stats of one timed class
  function automatic lsm_pkg::out_item_t timed_stats(input int c, input logic [31:0] delta);
    lsm_pkg::out_item_t r;
    r.stat_class    = 3'(c);
    r.last_delta_us = delta;
    r.min_us        = lat_min[c];
    r.max_us        = lat_max[c];
    r.event_count   = lat_count[c];
    r.average_us    = 32'(ring_total[c] / RING);
    return r;
  endfunction

  // Apply one event to the mirror; returns 1 when the event yields a result
  function automatic bit apply_event(input lsm_pkg::in_item_t it,
                                     output lsm_pkg::out_item_t res);
    int c;
    logic [63:0] span;
    logic [31:0] d;
    res = '0;
    if (it.opcode == lsm_pkg::OP_START) begin
      start_time = it.time_us;
      res.stat_class = lsm_pkg::CLS_START;
      return 1'b1;
    end
    if (it.opcode >= lsm_pkg::OP_READ_DONE && it.opcode <= lsm_pkg::OP_SYNC_DONE) begin
      c = int'(it.opcode - lsm_pkg::OP_READ_DONE);
      span = it.time_us - start_time;
      d = (span > 64'(lsm_pkg::SAT32)) ? lsm_pkg::SAT32 : span[31:0];
      if (d < lat_min[c]) lat_min[c] = d;
      if (d > lat_max[c]) lat_max[c] = d;
      lat_count[c] = lat_count[c] + 32'd1;
      // oldest sample leaves the sum as the new one enters
      ring_total[c] = ring_total[c] - 38'(sample_mem[c][ring_ptr[c]]) + 38'(d);
      sample_mem[c][ring_ptr[c]] = d;
      ring_ptr[c] = (ring_ptr[c] == RING - 1) ? 0 : ring_ptr[c] + 1;
      res = timed_stats(c, d);
      return 1'b1;
    end
    if (it.opcode >= lsm_pkg::OP_WARN_WRAP && it.opcode <= lsm_pkg::OP_WARN_FIFO_FULL) begin
      c = int'(it.opcode - lsm_pkg::OP_WARN_WRAP);
      warn_count[c] = warn_count[c] + 32'd1;
      res.stat_class  = lsm_pkg::CLS_WARN_WRAP + 3'(c);
      res.event_count = warn_count[c];
      return 1'b1;
    end
    if (it.opcode == lsm_pkg::OP_REPORT) begin
      if (it.report_class <= lsm_pkg::CLS_SYNC) begin
        res = timed_stats(int'(it.report_class), 32'd0);
      end else if (it.report_class < lsm_pkg::CLS_START) begin
        res.stat_class  = it.report_class;
        res.event_count = warn_count[int'(it.report_class - lsm_pkg::CLS_WARN_WRAP)];
      end else begin
        res.stat_class = lsm_pkg::CLS_START;
      end
      return 1'b1;
    end
    // unused opcodes are dropped
    return 1'b0;
  endfunction

  function automatic vector_t vec(input logic [3:0] op, input logic [63:0] t,
                                  input logic [2:0] rc, input logic typed,
                                  input lsm_pkg::out_item_t want);
    vector_t v;
    v.stim  = lsm_pkg::in_item_t'{op, t, rc};
    v.typed = typed;
    v.want  = want;
    return v;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [3:0] completion_op();
    return 4'(lsm_pkg::OP_READ_DONE + $urandom_range(2));
  endfunction

  // Elapsed times: mostly small, some near and past the 32-bit limit
  function automatic logic [63:0] pick_delta();
    int p;
    p = $urandom_range(99);
    if (p < 30) return 64'($urandom_range(255));
    if (p < 60) return 64'($urandom_range(20000));
    if (p < 75) return 64'h0_FFFF_FF00 + 64'($urandom_range(512));
    if (p < 85) return 64'($urandom());
    return rand64();
  endfunction

  // Offer one item, hold it until accepted, then update the mirror
  task automatic send_event(input lsm_pkg::in_item_t it, input logic typed,
                            input lsm_pkg::out_item_t want);
    lsm_pkg::out_item_t got;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (apply_event(it, got)) begin
      pending_stats.push_back(typed ? want : got);
      sent_events++;
    end
  endtask

  task automatic send_plain(input logic [3:0] op, input logic [63:0] t);
    send_event(lsm_pkg::in_item_t'{op, t, 3'($urandom_range(7))}, 1'b0, '0);
  endtask

  // Drain all results, then load a new minimum preload
  task automatic set_preload(input logic [31:0] v);
    in_valid <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    for (int c = 0; c < 3; c++) lat_min[c] = v;
  endtask

  // Random event streams: start/completion pairs, lone completions, warnings, reports, unused opcodes and bursts
  task automatic run_random(input int n);
    int target;
    int pick;
    int k;
    logic [63:0] t0;
    target = sent_events + n;
    while (sent_events < target) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        t0 = rand64();
        send_plain(lsm_pkg::OP_START, t0);
        send_plain(completion_op(), t0 + pick_delta());
      end else if (pick < 52) begin
        send_plain(completion_op(), start_time + pick_delta());
      end else if (pick < 62) begin
        send_plain(4'(lsm_pkg::OP_WARN_WRAP + $urandom_range(3)), rand64());
      end else if (pick < 77) begin
        send_plain(lsm_pkg::OP_REPORT, rand64());
      end else if (pick < 83) begin
        send_plain(4'($urandom_range(OP_UNUSED_HIGH, OP_UNUSED_LOW)), rand64());
      end else if (pick < 88) begin
        send_plain(lsm_pkg::OP_START, rand64());
        send_plain(completion_op(), rand64());
      end else begin
        // one start, a burst of completions
        t0 = rand64();
        send_plain(lsm_pkg::OP_START, t0);
        k = $urandom_range(6, 2);
        repeat (k) send_plain(completion_op(), t0 + pick_delta());
      end
    end
  endtask

  // Result checking
  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      failed = 1'b1;
    end
  endtask

  always @(posedge clk) begin : watch_results
    lsm_pkg::out_item_t oldest;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_stats.size() == 0) begin
        $error("unexpected result: class %0d count %0h", out_item.stat_class,
               out_item.event_count);
        failed = 1'b1;
      end else begin
        oldest = pending_stats.pop_front();
        check_field("stat_class", 32'(oldest.stat_class), 32'(out_item.stat_class));
        check_field("last_delta_us", oldest.last_delta_us, out_item.last_delta_us);
        check_field("min_us", oldest.min_us, out_item.min_us);
        check_field("max_us", oldest.max_us, out_item.max_us);
        check_field("event_count", oldest.event_count, out_item.event_count);
        check_field("average_us", oldest.average_us, out_item.average_us);
      end
    end
  end

  // Receiver: random stalls, one long hold-off once stress starts
  initial begin : receiver
    int  hold_left;
    bit  held;
    hold_left = 0;
    held      = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (stress_on && !held) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    vector_t rows[$];
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_item       = '0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    failed        = 1'b0;
    sent_events   = 0;
    send_idle_pct = 30;
    recv_idle_pct = 66;
    stress_on     = 1'b0;

    // mirror reset
    start_time  = '0;
    for (int c = 0; c < 3; c++) begin
      lat_min[c]    = lsm_pkg::MIN_PRELOAD_RESET;
      lat_max[c]    = '0;
      lat_count[c]  = '0;
      ring_ptr[c]   = 0;
      ring_total[c] = '0;
      for (int s = 0; s < RING; s++) sample_mem[c][s] = '0;
    end
    for (int w = 0; w < 4; w++) warn_count[w] = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: fresh state, no-start completion, wrap of the timestamp,
    // saturation edge, warnings, reports of every class, unused opcodes
    rows.push_back(vec(lsm_pkg::OP_REPORT, 64'd0, lsm_pkg::CLS_READ, 1'b1,
                       lsm_pkg::out_item_t'{lsm_pkg::CLS_READ, 32'd0,
                                            lsm_pkg::MIN_PRELOAD_RESET,
                                            32'd0, 32'd0, 32'd0}));
    rows.push_back(vec(lsm_pkg::OP_REPORT, 64'd0, lsm_pkg::CLS_START, 1'b1, START_RES));
    rows.push_back(vec(lsm_pkg::OP_REPORT, 64'd0, lsm_pkg::CLS_WARN_WRAP, 1'b1,
                       WRAP_ZERO_RES));
    rows.push_back(vec(lsm_pkg::OP_READ_DONE, 64'd5, lsm_pkg::CLS_READ, 1'b0, '0));
    rows.push_back(vec(lsm_pkg::OP_START, 64'd0, lsm_pkg::CLS_READ, 1'b1, START_RES));
    rows.push_back(vec(lsm_pkg::OP_READ_DONE, 64'd0, lsm_pkg::CLS_READ, 1'b0, '0));
    rows.push_back(vec(lsm_pkg::OP_START, 64'd100, lsm_pkg::CLS_READ, 1'b1, START_RES));
    rows.push_back(vec(OP_WRITE_DONE, '1, lsm_pkg::CLS_START, 1'b0, '0));
    rows.push_back(vec(lsm_pkg::OP_START, 64'hFFFF_FFFF_FFFF_FFF0, lsm_pkg::CLS_READ, 1'b1,
                       START_RES));
    rows.push_back(vec(lsm_pkg::OP_SYNC_DONE, 64'd5, lsm_pkg::CLS_READ, 1'b0, '0));
    rows.push_back(vec(lsm_pkg::OP_START, 64'd1000, lsm_pkg::CLS_READ, 1'b1, START_RES));
    rows.push_back(vec(lsm_pkg::OP_SYNC_DONE, 64'd1000 + 64'h0_FFFF_FFFF,
                       lsm_pkg::CLS_READ, 1'b0, '0));
    rows.push_back(vec(lsm_pkg::OP_SYNC_DONE, 64'd1000 + 64'h1_0000_0000,
                       lsm_pkg::CLS_READ, 1'b0, '0));
    rows.push_back(vec(lsm_pkg::OP_WARN_WRAP, 64'd0, lsm_pkg::CLS_READ, 1'b1,
                       lsm_pkg::out_item_t'{lsm_pkg::CLS_WARN_WRAP, 32'd0, 32'd0, 32'd0,
                                            32'd1, 32'd0}));
    rows.push_back(vec(OP_WARN_ALL_FULL, 64'd0, lsm_pkg::CLS_READ, 1'b1,
                       lsm_pkg::out_item_t'{CLS_WARN_ALL_FULL, 32'd0, 32'd0, 32'd0,
                                            32'd1, 32'd0}));
    rows.push_back(vec(OP_WARN_QUEUE_FULL, 64'd0, lsm_pkg::CLS_READ, 1'b1,
                       lsm_pkg::out_item_t'{CLS_WARN_QUEUE_FULL, 32'd0, 32'd0, 32'd0,
                                            32'd1, 32'd0}));
    rows.push_back(vec(lsm_pkg::OP_WARN_FIFO_FULL, 64'd0, lsm_pkg::CLS_READ, 1'b1,
                       lsm_pkg::out_item_t'{CLS_WARN_FIFO_FULL, 32'd0, 32'd0, 32'd0,
                                            32'd1, 32'd0}));
    rows.push_back(vec(lsm_pkg::OP_REPORT, 64'd0, CLS_WARN_ALL_FULL, 1'b1,
                       lsm_pkg::out_item_t'{CLS_WARN_ALL_FULL, 32'd0, 32'd0, 32'd0,
                                            32'd1, 32'd0}));
    rows.push_back(vec(lsm_pkg::OP_REPORT, 64'd0, CLS_WARN_QUEUE_FULL, 1'b1,
                       lsm_pkg::out_item_t'{CLS_WARN_QUEUE_FULL, 32'd0, 32'd0, 32'd0,
                                            32'd1, 32'd0}));
    rows.push_back(vec(lsm_pkg::OP_REPORT, 64'd0, CLS_WARN_FIFO_FULL, 1'b1,
                       lsm_pkg::out_item_t'{CLS_WARN_FIFO_FULL, 32'd0, 32'd0, 32'd0,
                                            32'd1, 32'd0}));
    rows.push_back(vec(lsm_pkg::OP_REPORT, 64'd0, CLS_WRITE, 1'b0, '0));
    rows.push_back(vec(lsm_pkg::OP_REPORT, 64'd0, lsm_pkg::CLS_SYNC, 1'b0, '0));
    rows.push_back(vec(OP_UNUSED_LOW, 64'd0, lsm_pkg::CLS_READ, 1'b0, '0));
    rows.push_back(vec(OP_UNUSED_HIGH, '1, lsm_pkg::CLS_START, 1'b0, '0));
    rows.push_back(vec(lsm_pkg::OP_REPORT, 64'd0, lsm_pkg::CLS_READ, 1'b0, '0));
    foreach (rows[i]) send_event(rows[i].stim, rows[i].typed, rows[i].want);

    // sender light, receiver heavy
    set_preload(32'd0);
    run_random(380);

    // sender heavy, receiver light
    send_idle_pct = 66;
    recv_idle_pct = 30;
    set_preload(32'hFFFF_FFFF);
    run_random(380);

    // no idling, with one long receiver hold-off to back the block up
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_preload($urandom());
    stress_on = 1'b1;
    run_random(380);

    set_preload(32'd1);
    run_random(390);

    // drain and let any stray result show up
    in_valid <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk);
    repeat (4 * DRAIN_CYCLES) @(posedge clk);

    if (!failed) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
